FILE: rtl/upd_pkg.sv
`default_nettype none

package upd_pkg;

    localparam int BYTE_W          = 8;
    localparam int OUT_COUNT_W     = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 24;
    localparam int M_TUSER_W       = 2;

    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic              has0;
        logic [BYTE_W-1:0] byte0;
        logic              has1;
        logic [BYTE_W-1:0] byte1;
        logic              is_end;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

endpackage

`default_nettype wire

FILE: rtl/upd_front.sv
`default_nettype none

module upd_front
    import upd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_last,
    input  wire logic              q_ready,
    output push_t                  q_push
);

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'b001,
        MODE_PCT   = 3'b010,
        MODE_DIGIT = 3'b100
    } mode_t;

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [BYTE_W-1:0] value_reg;
    logic [BYTE_W-1:0] value_next;

    logic              dig_ok;
    logic [3:0]        dig;
    logic [BYTE_W-1:0] val_shift;
    logic              plain_go;
    logic              a_en;
    logic [BYTE_W-1:0] a_byte;
    logic              b_en;
    logic [BYTE_W-1:0] b_byte;
    logic              c_en;
    logic [BYTE_W-1:0] c_byte;
    logic              accept;

    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    function automatic logic keep_byte(input logic [BYTE_W-1:0] v);
        return (v != '0) && (v != CHAR_CR);
    endfunction

    assign {dig_ok, dig} = hex_decode(in_byte);
    assign val_shift     = {value_reg[3:0], dig};
    assign s_tready      = q_ready;
    assign accept        = s_tvalid && q_ready;

    always_comb
    begin
        mode_next  = mode_reg;
        value_next = value_reg;
        plain_go   = 1'b0;
        a_en       = 1'b0;
        a_byte     = value_reg;
        b_en       = 1'b0;
        b_byte     = in_byte;
        c_en       = 1'b0;
        c_byte     = '0;
        case (mode_reg)
            MODE_PLAIN:
            begin
                plain_go = 1'b1;
            end
            MODE_PCT, MODE_DIGIT:
            begin
                if (dig_ok) begin
                    if (mode_reg == MODE_PCT) begin
                        mode_next  = MODE_DIGIT;
                        value_next = val_shift;
                    end else begin
                        a_en       = keep_byte(val_shift);
                        a_byte     = val_shift;
                        mode_next  = MODE_PLAIN;
                        value_next = '0;
                    end
                end else begin
                    a_en       = keep_byte(value_reg);
                    a_byte     = value_reg;
                    mode_next  = MODE_PLAIN;
                    value_next = '0;
                    plain_go   = 1'b1;
                end
            end
            default:
            begin
                mode_next  = MODE_PLAIN;
                value_next = '0;
                plain_go   = 1'b1;
            end
        endcase
        if (plain_go) begin
            if (in_byte == CHAR_PLUS) begin
                b_en   = 1'b1;
                b_byte = CHAR_SPACE;
            end else if (in_byte == CHAR_PCT) begin
                mode_next  = MODE_PCT;
                value_next = '0;
            end else begin
                b_en = 1'b1;
            end
        end
        if (in_last) begin
            if (mode_next != MODE_PLAIN) begin
                c_en   = keep_byte(value_next);
                c_byte = value_next;
            end
            mode_next  = MODE_PLAIN;
            value_next = '0;
        end
    end

    always_comb
    begin
        q_push.cmd.has0   = a_en || b_en || c_en;
        q_push.cmd.byte0  = a_en ? a_byte : (b_en ? b_byte : c_byte);
        q_push.cmd.has1   = a_en && b_en;
        q_push.cmd.byte1  = b_byte;
        q_push.cmd.is_end = in_last;
        q_push.push       = accept && (a_en || b_en || c_en || in_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_PLAIN;
            value_reg <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            value_reg <= value_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.push && q_push.cmd.has1 |-> q_push.cmd.has0)
        else $error("second byte without first");
    a_end_clears_mode: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> mode_reg == MODE_PLAIN && value_reg == '0)
        else $error("escape state survives end of string");
    a_pct_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_PCT |-> value_reg == '0)
        else $error("escape value set before first digit");
`endif

endmodule

`default_nettype wire

FILE: rtl/upd_queue.sv
`default_nettype none

module upd_queue
    import upd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t q_push,
    output logic       q_ready,
    output head_t      q_head,
    input  wire logic  q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_ready      = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign q_head.valid = (cnt_reg != '0);
    assign q_head.cmd   = mem_reg[rd_ptr_reg];
    assign do_push      = q_push.push && q_ready;
    assign do_pop       = q_pop && q_head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("pop from empty queue");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("pointers disagree on empty queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/upd_back.sv
`default_nettype none

module upd_back
    import upd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire head_t                q_head,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [M_TUSER_W-1:0]      m_tuser,
    output logic                      m_tlast
);

    logic                   phase_reg;
    logic                   phase_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   tvalid_reg;
    logic                   tvalid_next;
    logic [BYTE_W-1:0]      byte_reg;
    logic                   valid_reg;
    logic                   last_reg;
    logic                   end_reg;
    logic [OUT_COUNT_W-1:0] dcount_reg;

    logic                   load;
    logic                   split;
    logic [BYTE_W-1:0]      res_byte;
    logic                   res_valid;
    logic                   res_last;
    logic                   res_end;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [COUNT_WIDTH-1:0] count_new;

    assign load      = q_head.valid && (!tvalid_reg || m_tready);
    assign split     = !phase_reg && q_head.cmd.has1;
    assign res_byte  = phase_reg ? q_head.cmd.byte1 : q_head.cmd.byte0;
    assign res_valid = phase_reg || q_head.cmd.has0;
    assign res_last  = !split;
    assign res_end   = q_head.cmd.is_end && res_last;
    assign cnt_inc   = (count_reg == {COUNT_WIDTH{1'b1}}) ? count_reg : count_reg + 1'b1;
    assign count_new = res_valid ? cnt_inc : count_reg;
    assign q_pop     = load && res_last;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        tvalid_next = tvalid_reg;
        if (load) begin
            phase_next  = split;
            count_next  = res_end ? '0 : count_new;
            tvalid_next = 1'b1;
        end else if (m_tready) begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= 1'b0;
            count_reg  <= '0;
            tvalid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg   <= res_valid ? res_byte : '0;
            valid_reg  <= res_valid;
            last_reg   <= res_last;
            end_reg    <= res_end;
            dcount_reg <= OUT_COUNT_W'(count_new);
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = {dcount_reg, byte_reg};
    assign m_tuser  = {last_reg, valid_reg};
    assign m_tlast  = end_reg;

`ifndef NO_ASSERTIONS
    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        tvalid_reg && !valid_reg |-> last_reg && end_reg)
        else $error("bare marker not final");
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        tvalid_reg && end_reg |-> last_reg)
        else $error("end of string before last of step");
    a_phase_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> q_head.valid)
        else $error("second byte pending without command");
    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load && res_end |=> count_reg == '0)
        else $error("count not cleared after end of string");
`endif

endmodule

`default_nettype wire

FILE: rtl/url_percent_decoder_unit.sv
`default_nettype none

// URL percent decoder. Accepts one encoded character per cycle on the slave
// stream while the command queue has room, and gives decoded bytes on the
// master stream: '+' becomes a space, '%' followed by up to two hex digits
// becomes the byte they spell, and an escape of value zero or carriage return
// is dropped. The front stage keeps the escape state and turns each input
// transaction into a command of zero, one or two bytes plus an end-of-string
// flag; a two-entry command queue feeds the back stage, which keeps the
// saturating byte count and sends one result per cycle, unless m_tready
// stalls it, through its output register. Throughput is one input per cycle
// while each input yields at most one result and the output is not stalled;
// a two-byte input holds the queue head until its second byte is sent. An
// input with tlast and no decoded byte yields one result with tuser[0] low.
module url_percent_decoder_unit
    import upd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] in_byte
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [7:0] out_byte, [23:8] decoded_count
    output logic [M_TUSER_W-1:0]      m_tuser,   // [0] out_valid, [1] out_last
    output logic                      m_tlast
);

    push_t q_push;
    head_t q_head;
    logic  q_ready;
    logic  q_pop;

    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_byte  (s_tdata[BYTE_W-1:0]),
        .in_last  (s_tlast),
        .q_ready  (q_ready),
        .q_push   (q_push)
    );

    upd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_ready (q_ready),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    upd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
